### sv/psg_tone_noise_stereo_mixer_assert.svh
// Assertion macros shared by the sound generator RTL.
// Expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef PSG_TONE_NOISE_STEREO_MIXER_ASSERT_SVH
`define PSG_TONE_NOISE_STEREO_MIXER_ASSERT_SVH
// Same-cycle implication, masked while reset is held.
`define PSGTN_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);
// Next-cycle implication, masked while reset is held.
`define PSGTN_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);
`endif

### sv/psgtn_pkg.sv
// Package for the tone/noise sound generator: codes, types, reset values and
// the attenuation-to-amplitude table. No dependencies.
`timescale 1ns / 1ps

package psgtn_pkg;

  localparam int          FRAC_BITS_DEF = 8;
  localparam logic [15:0] CPS_RESET     = 16'd20779;
  localparam logic [15:0] NOISE_SEED    = 16'h8000;
  localparam logic [7:0]  ROUTING_RESET = 8'hFF;
  localparam logic [3:0]  ATTEN_OFF     = 4'hF;
  localparam logic [1:0]  NOISE_CH      = 2'd3;

  // Noise rate codes and their fixed periods.
  localparam logic [1:0] NOISE_RATE_16  = 2'd0;
  localparam logic [1:0] NOISE_RATE_32  = 2'd1;
  localparam logic [1:0] NOISE_RATE_64  = 2'd2;
  localparam logic [1:0] NOISE_RATE_T2  = 2'd3;
  localparam logic [9:0] NOISE_PER_16   = 10'h010;
  localparam logic [9:0] NOISE_PER_32   = 10'h020;
  localparam logic [9:0] NOISE_PER_64   = 10'h040;

  // Configuration register index.
  localparam logic REG_CPS = 1'b0;

  typedef enum logic [1:0] {
    FUNC_DATA   = 2'd0,
    FUNC_STEREO = 2'd1,
    FUNC_TICK   = 2'd2,
    FUNC_NONE   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_ADD  = 2'd1,
    ST_SUB  = 2'd2,
    ST_MIX  = 2'd3
  } state_t;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

  // Everything the mixer needs to know about the four channels.
  typedef struct packed {
    logic [3:0]      active;
    logic [3:0]      level;
    logic [3:0][3:0] atten;
    logic [7:0]      routing;
  } mix_in_t;

  function automatic logic [13:0] amp_of(input logic [3:0] atten);
    logic [13:0] amp;
    unique case (atten)
      4'd0:    amp = 14'd8192;
      4'd1:    amp = 14'd6507;
      4'd2:    amp = 14'd5168;
      4'd3:    amp = 14'd4105;
      4'd4:    amp = 14'd3261;
      4'd5:    amp = 14'd2590;
      4'd6:    amp = 14'd2057;
      4'd7:    amp = 14'd1634;
      4'd8:    amp = 14'd1298;
      4'd9:    amp = 14'd1031;
      4'd10:   amp = 14'd819;
      4'd11:   amp = 14'd650;
      4'd12:   amp = 14'd516;
      4'd13:   amp = 14'd410;
      4'd14:   amp = 14'd326;
      default: amp = 14'd0;
    endcase
    return amp;
  endfunction

endpackage

### sv/psgtn_alu.sv
// Shared add/subtract unit used for every counter step of the sequencer.
// Depends on psgtn_pkg for the operation code.
`timescale 1ns / 1ps

module psgtn_alu #(
  parameter int W = 23
) (
  input  psgtn_pkg::alu_op_t op,
  input  logic [W-1:0]       a,
  input  logic [W-1:0]       b,
  output logic [W-1:0]       res,
  output logic               ge
);

  logic [W:0] sum;
  logic [W:0] b_ext;
  logic       sub;

  assign sub   = (op == psgtn_pkg::ALU_SUB);
  assign b_ext = sub ? {1'b0, ~b} : {1'b0, b};
  assign sum   = {1'b0, a} + b_ext + {{W{1'b0}}, sub};
  assign res   = sum[W-1:0];
  // On a subtract the carry out is set exactly when a is not below b.
  assign ge    = sum[W];

endmodule

### sv/psgtn_mixer.sv
// Stereo mixer: routes signed channel amplitudes and saturates each sum to 16 bits.
// Depends on psgtn_pkg for the channel bundle type and the amplitude table.
`timescale 1ns / 1ps

module psgtn_mixer (
  input  psgtn_pkg::mix_in_t mix_i,
  output logic signed [15:0] left_o,
  output logic signed [15:0] right_o
);

  localparam int SUM_W = 18;
  localparam logic signed [SUM_W-1:0] SAT_MAX = 18'sd32767;
  localparam logic signed [SUM_W-1:0] SAT_MIN = -18'sd32768;

  logic signed [SUM_W-1:0] sum_l;
  logic signed [SUM_W-1:0] sum_r;

  always_comb begin
    logic signed [SUM_W-1:0] amp;
    logic signed [SUM_W-1:0] sgn;
    sum_l = '0;
    sum_r = '0;
    for (int i = 0; i < 4; i++) begin
      amp = $signed({4'b0, psgtn_pkg::amp_of(mix_i.atten[i])});
      sgn = mix_i.level[i] ? amp : -amp;
      if (mix_i.active[i] && mix_i.routing[4 + i]) begin
        sum_l = sum_l + sgn;
      end
      if (mix_i.active[i] && mix_i.routing[i]) begin
        sum_r = sum_r + sgn;
      end
    end
  end

  function automatic logic signed [15:0] sat16(input logic signed [SUM_W-1:0] v);
    logic signed [15:0] r;
    priority if (v > SAT_MAX) begin
      r = 16'sh7FFF;
    end else if (v < SAT_MIN) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  assign left_o  = sat16(sum_l);
  assign right_o = sat16(sum_r);

endmodule

### sv/psg_tone_noise_stereo_mixer.sv
// Top level of the three-tone plus noise sound generator with stereo mixer.
// Depends on psgtn_pkg, psgtn_alu, psgtn_mixer and the assertion macro header.
`timescale 1ns / 1ps
//
// Usage. The input channel (in_valid/in_ready, in_func, in_data_byte) carries
// one command per beat: a chip data byte write, a stereo routing write, or a
// sample tick. Only a tick produces a beat on the output channel (out_valid/
// out_ready, out_left_sample, out_right_sample). The APB-style port sets
// cycles_per_sample (8.8 style fixed point, FRAC_BITS fraction bits) at
// byte address 0; write it only while the block is idle.
//
// Timing. A write command leaves the block idle, so the next beat can follow
// directly. A tick runs the four channel counters through one shared adder:
// each silent channel takes one add step, each sounding channel takes an add
// step, one subtract step per threshold crossing (tone toggle or noise shift)
// and a last subtract step, and a final mix step loads the mixed sample.
// Shortening a period below a large leftover count adds one subtract step per
// extra crossing. in_ready is low while a tick is running.
//
// Reset (rst_n low at a clock edge) restores all chip registers, counters and
// the LFSR seed, and empties the output register. If the receiver stalls, the
// finished sample stays in the output register; further writes are still
// accepted, but the next tick waits in its mix step until the slot is free.

`include "psg_tone_noise_stereo_mixer_assert.svh"

module psg_tone_noise_stereo_mixer #(
  parameter int FRAC_BITS = psgtn_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  // Command channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_func,
  input  logic [7:0]         in_data_byte,
  // Sample channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_left_sample,
  output logic signed [15:0] out_right_sample,
  // Configuration port
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [2:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);

  // A counter stays below one threshold (period * 16 in fixed point, at most
  // 14 + FRAC_BITS bits) plus one increment, which is below 2^16.
  localparam int CNT_W = FRAC_BITS + 15;
  localparam int TH_SH = FRAC_BITS + 4;

  // Chip registers
  logic [15:0]           cps_r,          cps_nxt;
  logic [2:0][9:0]       tone_period_r,  tone_period_nxt;
  logic [2:0][3:0]       tone_atten_r,   tone_atten_nxt;
  logic [2:0]            tone_en_r,      tone_en_nxt;
  logic [2:0]            tone_level_r,   tone_level_nxt;
  logic [2:0]            noise_mode_r,   noise_mode_nxt;
  logic [3:0]            noise_atten_r,  noise_atten_nxt;
  logic [15:0]           noise_shift_r,  noise_shift_nxt;
  logic [7:0]            routing_r,      routing_nxt;
  logic [2:0]            latch_r,        latch_nxt;
  logic [CNT_W-1:0]      cnt_r [4];
  logic [CNT_W-1:0]      cnt_nxt [4];

  // Sequencer and output register
  psgtn_pkg::state_t     state_r,        state_nxt;
  logic [1:0]            ch_r,           ch_nxt;
  logic                  out_valid_r,    out_valid_nxt;
  logic signed [15:0]    out_left_r,     out_left_nxt;
  logic signed [15:0]    out_right_r,    out_right_nxt;

  // Control from the sequencer output decode
  logic                  in_accept;
  logic                  cfg_write;
  logic                  step_add;
  logic                  step_sub;
  logic                  ch_adv;
  logic                  mix_go;
  psgtn_pkg::alu_op_t    alu_op;

  // Datapath
  logic [3:0]            act;
  logic [9:0]            per_sel;
  logic [9:0]            per_nz;
  logic [CNT_W-1:0]      th;
  logic [CNT_W-1:0]      alu_b;
  logic [CNT_W-1:0]      alu_res;
  logic                  alu_ge;
  logic                  noise_fb;
  psgtn_pkg::mix_in_t    mix_in;
  logic signed [15:0]    mix_left;
  logic signed [15:0]    mix_right;

  assign in_accept  = in_valid && in_ready;
  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == psgtn_pkg::REG_CPS) ? {16'b0, cps_r} : '0;

  // A channel sounds when it is enabled and not fully attenuated.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      act[i] = tone_en_r[i] && (tone_atten_r[i] != psgtn_pkg::ATTEN_OFF);
    end
    act[3] = (noise_atten_r != psgtn_pkg::ATTEN_OFF);
  end

  // Period of the channel under work; the noise may borrow tone 2's period.
  always_comb begin
    unique case (ch_r)
      2'd0: per_sel = tone_period_r[0];
      2'd1: per_sel = tone_period_r[1];
      2'd2: per_sel = tone_period_r[2];
      default: begin
        unique case (noise_mode_r[1:0])
          psgtn_pkg::NOISE_RATE_16: per_sel = psgtn_pkg::NOISE_PER_16;
          psgtn_pkg::NOISE_RATE_32: per_sel = psgtn_pkg::NOISE_PER_32;
          psgtn_pkg::NOISE_RATE_64: per_sel = psgtn_pkg::NOISE_PER_64;
          default:                  per_sel = tone_period_r[2];
        endcase
      end
    endcase
  end

  // A zero period behaves as a period of one.
  assign per_nz = (per_sel == '0) ? 10'd1 : per_sel;
  assign th     = CNT_W'(per_nz) << TH_SH;
  assign alu_b  = (alu_op == psgtn_pkg::ALU_SUB) ? th : CNT_W'(cps_r);

  psgtn_alu #(
    .W (CNT_W)
  ) u_alu (
    .op  (alu_op),
    .a   (cnt_r[ch_r]),
    .b   (alu_b),
    .res (alu_res),
    .ge  (alu_ge)
  );

  // Feedback of the noise LFSR: tapped in white mode, plain rotate otherwise.
  assign noise_fb = noise_mode_r[2] ? (noise_shift_r[0] ^ noise_shift_r[3])
                                    : noise_shift_r[0];

  assign mix_in.active  = act;
  assign mix_in.level   = {noise_shift_r[0], tone_level_r};
  assign mix_in.atten   = {noise_atten_r, tone_atten_r[2], tone_atten_r[1], tone_atten_r[0]};
  assign mix_in.routing = routing_r;

  psgtn_mixer u_mixer (
    .mix_i   (mix_in),
    .left_o  (mix_left),
    .right_o (mix_right)
  );

  // Sequencer output decode.
  always_comb begin
    in_ready = 1'b0;
    alu_op   = psgtn_pkg::ALU_ADD;
    step_add = 1'b0;
    step_sub = 1'b0;
    ch_adv   = 1'b0;
    mix_go   = 1'b0;
    unique case (state_r)
      psgtn_pkg::ST_IDLE: begin
        in_ready = 1'b1;
      end
      psgtn_pkg::ST_ADD: begin
        step_add = act[ch_r];
        ch_adv   = !act[ch_r];
      end
      psgtn_pkg::ST_SUB: begin
        alu_op   = psgtn_pkg::ALU_SUB;
        step_sub = alu_ge;
        ch_adv   = !alu_ge;
      end
      psgtn_pkg::ST_MIX: begin
        mix_go = !out_valid_r || out_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      psgtn_pkg::ST_IDLE: begin
        if (in_accept && (in_func == psgtn_pkg::FUNC_TICK)) begin
          state_nxt = psgtn_pkg::ST_ADD;
        end
      end
      psgtn_pkg::ST_ADD: begin
        if (step_add) begin
          state_nxt = psgtn_pkg::ST_SUB;
        end else if (ch_r == psgtn_pkg::NOISE_CH) begin
          state_nxt = psgtn_pkg::ST_MIX;
        end
      end
      psgtn_pkg::ST_SUB: begin
        if (ch_adv) begin
          state_nxt = (ch_r == psgtn_pkg::NOISE_CH) ? psgtn_pkg::ST_MIX : psgtn_pkg::ST_ADD;
        end
      end
      psgtn_pkg::ST_MIX: begin
        if (mix_go) begin
          state_nxt = psgtn_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = psgtn_pkg::ST_IDLE;
      end
    endcase
  end

  // Register updates: configuration, command decode, counter steps, output.
  always_comb begin
    cps_nxt         = cps_r;
    tone_period_nxt = tone_period_r;
    tone_atten_nxt  = tone_atten_r;
    tone_en_nxt     = tone_en_r;
    tone_level_nxt  = tone_level_r;
    noise_mode_nxt  = noise_mode_r;
    noise_atten_nxt = noise_atten_r;
    noise_shift_nxt = noise_shift_r;
    routing_nxt     = routing_r;
    latch_nxt       = latch_r;
    cnt_nxt         = cnt_r;
    ch_nxt          = ch_adv ? ch_r + 2'd1 : ch_r;
    out_left_nxt    = out_left_r;
    out_right_nxt   = out_right_r;
    out_valid_nxt   = out_valid_r && !out_ready;

    if (cfg_write && (cfg_paddr[2] == psgtn_pkg::REG_CPS)) begin
      cps_nxt = cfg_pwdata[15:0];
    end

    if (in_accept && (in_func == psgtn_pkg::FUNC_STEREO)) begin
      routing_nxt = in_data_byte;
    end

    if (in_accept && (in_func == psgtn_pkg::FUNC_DATA)) begin
      if (in_data_byte[7]) begin
        // Latch byte: channel in bits 6..5, volume flag in bit 4.
        latch_nxt = {in_data_byte[4], in_data_byte[6:5]};
        if (in_data_byte[6:5] != psgtn_pkg::NOISE_CH) begin
          for (int i = 0; i < 3; i++) begin
            if (in_data_byte[6:5] == 2'(i)) begin
              if (in_data_byte[4]) begin
                tone_atten_nxt[i] = in_data_byte[3:0];
                tone_en_nxt[i]    = (in_data_byte[3:0] != psgtn_pkg::ATTEN_OFF);
              end else begin
                tone_period_nxt[i][3:0] = in_data_byte[3:0];
                tone_en_nxt[i]          = 1'b1;
              end
            end
          end
        end else if (in_data_byte[4]) begin
          noise_atten_nxt = in_data_byte[3:0];
        end else begin
          // A noise control write restarts the generator from its seed.
          noise_mode_nxt  = in_data_byte[2:0];
          noise_shift_nxt = psgtn_pkg::NOISE_SEED;
          cnt_nxt[3]      = '0;
        end
      end else if ((latch_r[1:0] != psgtn_pkg::NOISE_CH) && !latch_r[2]) begin
        for (int i = 0; i < 3; i++) begin
          if (latch_r[1:0] == 2'(i)) begin
            tone_period_nxt[i][9:4] = in_data_byte[5:0];
            tone_en_nxt[i]          = 1'b1;
          end
        end
      end
    end

    if (step_add || step_sub) begin
      cnt_nxt[ch_r] = alu_res;
    end

    if (step_sub) begin
      if (ch_r == psgtn_pkg::NOISE_CH) begin
        noise_shift_nxt = {noise_fb, noise_shift_r[15:1]};
      end else begin
        for (int i = 0; i < 3; i++) begin
          if (ch_r == 2'(i)) begin
            tone_level_nxt[i] = !tone_level_r[i];
          end
        end
      end
    end

    if (mix_go) begin
      out_left_nxt  = mix_left;
      out_right_nxt = mix_right;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cps_r         <= psgtn_pkg::CPS_RESET;
      tone_period_r <= '0;
      tone_atten_r  <= '0;
      tone_en_r     <= '0;
      tone_level_r  <= '0;
      noise_mode_r  <= '0;
      noise_atten_r <= psgtn_pkg::ATTEN_OFF;
      noise_shift_r <= psgtn_pkg::NOISE_SEED;
      routing_r     <= psgtn_pkg::ROUTING_RESET;
      latch_r       <= '0;
      for (int i = 0; i < 4; i++) begin
        cnt_r[i] <= '0;
      end
      state_r       <= psgtn_pkg::ST_IDLE;
      ch_r          <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      cps_r         <= cps_nxt;
      tone_period_r <= tone_period_nxt;
      tone_atten_r  <= tone_atten_nxt;
      tone_en_r     <= tone_en_nxt;
      tone_level_r  <= tone_level_nxt;
      noise_mode_r  <= noise_mode_nxt;
      noise_atten_r <= noise_atten_nxt;
      noise_shift_r <= noise_shift_nxt;
      routing_r     <= routing_nxt;
      latch_r       <= latch_nxt;
      for (int i = 0; i < 4; i++) begin
        cnt_r[i] <= cnt_nxt[i];
      end
      state_r       <= state_nxt;
      ch_r          <= ch_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // Sample payload needs no reset; it is qualified by out_valid_r.
  always_ff @(posedge clk) begin
    out_left_r  <= out_left_nxt;
    out_right_r <= out_right_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_left_sample  = out_left_r;
  assign out_right_sample = out_right_r;

  // The channel pointer is back at the first tone whenever the block is idle.
  `PSGTN_ASSERT_NOW(a_idle_ch_zero, state_r == psgtn_pkg::ST_IDLE, ch_r == 2'd0, "channel pointer not cleared in idle")
  // A finished sample is held in the mix step while the output slot is full.
  `PSGTN_ASSERT_NEXT(a_mix_waits, (state_r == psgtn_pkg::ST_MIX) && out_valid_r && !out_ready, state_r == psgtn_pkg::ST_MIX, "mix step left while output blocked")
  // Leaving the mix step always presents a sample and returns to idle.
  `PSGTN_ASSERT_NEXT(a_mix_loads, (state_r == psgtn_pkg::ST_MIX) && (!out_valid_r || out_ready), out_valid_r && (state_r == psgtn_pkg::ST_IDLE), "mix step did not load sample")
  // Register writes never produce a sample.
  `PSGTN_ASSERT_NEXT(a_write_silent, in_valid && in_ready && (in_func != psgtn_pkg::FUNC_TICK), !$rose(out_valid_r), "write command produced a sample")

endmodule

### tb/psg_tone_noise_stereo_mixer_test.sv
// Self-checking bench for psg_tone_noise_stereo_mixer: directed and random command beats,
// a scoreboard class that predicts every stereo sample, and random stalls on both channels.
// Depends on psgtn_pkg and the psg_tone_noise_stereo_mixer RTL.
`timescale 1ns / 1ps

module psg_tone_noise_stereo_mixer_test;

  // The slowest legal run stays far below this. It allows for long receiver stalls,
  // long sender gaps and ticks that follow a period cut under a large leftover count.
  localparam int CYCLE_LIMIT   = 2_000_000;
  // Quiet time after the last sample before a register write, and at the end.
  localparam int SETTLE_CYCLES = 16;
  // Length of the deliberate receiver hold-off that backs the block up.
  localparam int FREEZE_CYCLES = 400;
  localparam int PHASE_BEATS   = 272;
  localparam int NUM_PHASES    = 6;
  localparam logic [2:0] RATE_ADDR = {psgtn_pkg::REG_CPS, 2'b00};

  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] right;
  } stereo_sample_t;

  // Shadow copy of the chip. Every accepted command beat is applied here, and every
  // tick leaves one expected stereo sample in the pending queue.
  class psg_sample_ledger;
    logic [15:0]    rate;
    logic [9:0]     period [3];
    logic [3:0]     atten [3];
    bit             enabled [3];
    bit             level [3];
    int unsigned    count [3];
    logic [2:0]     noise_mode;
    logic [3:0]     noise_atten;
    int unsigned    noise_count;
    logic [15:0]    lfsr;
    bit             noise_level;
    logic [7:0]     routing;
    logic [2:0]     latched;
    int             amp [16];
    stereo_sample_t pending [$];
    int             fail_count;

    function new();
      amp = '{8192, 6507, 5168, 4105, 3261, 2590, 2057, 1634,
              1298, 1031, 819, 650, 516, 410, 326, 0};
      fail_count = 0;
      rate = psgtn_pkg::CPS_RESET;
      for (int i = 0; i < 3; i++) begin
        period[i]  = '0;
        atten[i]   = '0;
        enabled[i] = 1'b0;
        level[i]   = 1'b0;
        count[i]   = 0;
      end
      noise_mode  = '0;
      noise_atten = psgtn_pkg::ATTEN_OFF;
      noise_count = 0;
      lfsr        = psgtn_pkg::NOISE_SEED;
      noise_level = 1'b0;
      routing     = psgtn_pkg::ROUTING_RESET;
      latched     = '0;
    endfunction

    task report(string msg);
      fail_count++;
      $display("[%0t] mismatch: %s", $time, msg);
    endtask

    function void set_rate(logic [15:0] v);
      rate = v;
    endfunction

    // Counter amount for one toggle or shift, in fixed point.
    function int unsigned crossing_span(logic [9:0] p);
      int unsigned cyc;
      cyc = (p == 10'd0) ? 1 : p;
      return cyc << (4 + psgtn_pkg::FRAC_BITS_DEF);
    endfunction

    function void write_chip(logic [7:0] b);
      logic [1:0] ch;
      ch = b[6:5];
      if (b[7]) begin
        latched = {b[4], ch};
        if (ch != psgtn_pkg::NOISE_CH) begin
          if (b[4]) begin
            atten[ch]   = b[3:0];
            enabled[ch] = (b[3:0] != psgtn_pkg::ATTEN_OFF);
          end else begin
            period[ch][3:0] = b[3:0];
            enabled[ch]     = 1'b1;
          end
        end else if (b[4]) begin
          noise_atten = b[3:0];
        end else begin
          noise_mode  = b[2:0];
          lfsr        = psgtn_pkg::NOISE_SEED;
          noise_count = 0;
          noise_level = 1'b0;
        end
      end else if (latched[1:0] != psgtn_pkg::NOISE_CH && !latched[2]) begin
        period[latched[1:0]][9:4] = b[5:0];
        enabled[latched[1:0]]     = 1'b1;
      end
    endfunction

    function void advance_channels();
      int unsigned span;
      logic [9:0]  noise_per;
      for (int i = 0; i < 3; i++) begin
        if (enabled[i] && atten[i] != psgtn_pkg::ATTEN_OFF) begin
          span = crossing_span(period[i]);
          count[i] += rate;
          while (count[i] >= span) begin
            count[i] -= span;
            level[i] = !level[i];
          end
        end
      end
      if (noise_atten != psgtn_pkg::ATTEN_OFF) begin
        case (noise_mode[1:0])
          psgtn_pkg::NOISE_RATE_16: noise_per = psgtn_pkg::NOISE_PER_16;
          psgtn_pkg::NOISE_RATE_32: noise_per = psgtn_pkg::NOISE_PER_32;
          psgtn_pkg::NOISE_RATE_64: noise_per = psgtn_pkg::NOISE_PER_64;
          psgtn_pkg::NOISE_RATE_T2: noise_per = period[2];
        endcase
        span = crossing_span(noise_per);
        noise_count += rate;
        while (noise_count >= span) begin
          noise_count -= span;
          lfsr = {(noise_mode[2] ? (lfsr[0] ^ lfsr[3]) : lfsr[0]), lfsr[15:1]};
          noise_level = lfsr[0];
        end
      end
    endfunction

    function void route(int c, logic [3:0] a, bit lv, inout int l, inout int r);
      int s;
      s = lv ? amp[a] : -amp[a];
      if (routing[4 + c]) l += s;
      if (routing[c]) r += s;
    endfunction

    function logic signed [15:0] saturate(int v);
      if (v > 32767) return 16'sh7FFF;
      if (v < -32768) return 16'sh8000;
      return v[15:0];
    endfunction

    function stereo_sample_t mix_channels();
      int             l;
      int             r;
      stereo_sample_t smp;
      l = 0;
      r = 0;
      for (int c = 0; c < 3; c++) begin
        if (enabled[c] && atten[c] != psgtn_pkg::ATTEN_OFF) route(c, atten[c], level[c], l, r);
      end
      if (noise_atten != psgtn_pkg::ATTEN_OFF) route(3, noise_atten, noise_level, l, r);
      smp.left  = saturate(l);
      smp.right = saturate(r);
      return smp;
    endfunction

    function void take_command(psgtn_pkg::func_t f, logic [7:0] b);
      stereo_sample_t smp;
      case (f)
        psgtn_pkg::FUNC_DATA:   write_chip(b);
        psgtn_pkg::FUNC_STEREO: routing = b;
        psgtn_pkg::FUNC_TICK: begin
          advance_channels();
          smp = mix_channels();
          pending.insert(pending.size(), smp);
        end
        psgtn_pkg::FUNC_NONE: ;
      endcase
    endfunction

    task match_sample(logic signed [15:0] got_l, logic signed [15:0] got_r);
      stereo_sample_t want;
      if (pending.size() == 0) begin
        report($sformatf("sample %0d/%0d with nothing outstanding", got_l, got_r));
        return;
      end
      want = pending.pop_front();
      if (got_l !== want.left)
        report($sformatf("left sample %0d, predicted %0d", got_l, want.left));
      if (got_r !== want.right)
        report($sformatf("right sample %0d, predicted %0d", got_r, want.right));
    endtask
  endclass

  // Every block input starts at a known value; reset is held from time zero.
  logic               clk          = 1'b0;
  logic               rst_n        = 1'b0;
  logic               in_valid     = 1'b0;
  logic               in_ready;
  logic [1:0]         in_func      = psgtn_pkg::FUNC_NONE;
  logic [7:0]         in_data_byte = 8'h00;
  logic               out_valid;
  logic               out_ready    = 1'b0;
  logic signed [15:0] out_left_sample;
  logic signed [15:0] out_right_sample;
  logic               cfg_psel     = 1'b0;
  logic               cfg_penable  = 1'b0;
  logic               cfg_pwrite   = 1'b0;
  logic [2:0]         cfg_paddr    = '0;
  logic [31:0]        cfg_pwdata   = '0;
  logic [31:0]        cfg_prdata;
  logic               cfg_pready;

  psg_sample_ledger ledger = new();

  // Per-phase traffic shape. An eager side never idles; the freeze request asks the
  // receiver for one long hold-off so the finished sample blocks the next tick.
  bit source_eager    = 1'b0;
  bit sink_eager      = 1'b0;
  bit sink_freeze_req = 1'b0;

  always #6 clk = ~clk;

  psg_tone_noise_stereo_mixer i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_func          (in_func),
    .in_data_byte     (in_data_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_left_sample  (out_left_sample),
    .out_right_sample (out_right_sample),
    .cfg_psel         (cfg_psel),
    .cfg_penable      (cfg_penable),
    .cfg_pwrite       (cfg_pwrite),
    .cfg_paddr        (cfg_paddr),
    .cfg_pwdata       (cfg_pwdata),
    .cfg_prdata       (cfg_prdata),
    .cfg_pready       (cfg_pready)
  );

  // Idle length for either side: mostly none or short, now and then a long one.
  function automatic int draw_gap(input bit eager);
    int roll;
    roll = $urandom_range(0, 99);
    if (eager || roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(30, 80);
  endfunction

  // Random command mix. About half are ticks. Chip writes are mostly well-formed
  // latch/data sequences with small periods and loud attenuations, so that tones
  // toggle and noise shifts often; raw bytes and the unused code supply the noise.
  function automatic void pick_command(output psgtn_pkg::func_t f, output logic [7:0] b);
    int         roll;
    logic [1:0] ch;
    logic [3:0] nib;
    roll = $urandom_range(0, 99);
    ch   = 2'($urandom_range(0, 2));
    nib  = ($urandom_range(0, 1) == 1) ? 4'($urandom_range(0, 2)) : 4'($urandom);
    f    = psgtn_pkg::FUNC_DATA;
    b    = 8'($urandom);
    if (roll < 48) begin
      f = psgtn_pkg::FUNC_TICK;
    end else if (roll < 56) begin
      f = psgtn_pkg::FUNC_STEREO;
      if ($urandom_range(0, 1) == 1) b = psgtn_pkg::ROUTING_RESET;
    end else if (roll < 59) begin
      f = psgtn_pkg::FUNC_NONE;
    end else if (roll < 69) begin
      b = {1'b1, ch, 1'b0, 4'($urandom)};
    end else if (roll < 79) begin
      // Upper period bits; kept small most of the time.
      b = {1'b0, 7'($urandom)};
      if ($urandom_range(0, 9) < 6) b[5:2] = 4'd0;
    end else if (roll < 88) begin
      b = {1'b1, ch, 1'b1, nib};
    end else if (roll < 93) begin
      b = {1'b1, psgtn_pkg::NOISE_CH, 1'b1, nib};
    end else if (roll < 96) begin
      b = {1'b1, psgtn_pkg::NOISE_CH, 1'b0, 4'($urandom)};
    end
  endfunction

  // Offer one command beat, hold it until taken, then idle for a random gap.
  // The scoreboard sees the beat at the edge that accepts it.
  task automatic issue(input psgtn_pkg::func_t f, input logic [7:0] b);
    int gap;
    in_valid     <= 1'b1;
    in_func      <= f;
    in_data_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    ledger.take_command(f, b);
    gap = draw_gap(source_eager);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop sending and wait for every predicted sample, then give any trailing
  // write command time to finish before the block is touched again.
  task automatic await_quiet();
    in_valid <= 1'b0;
    while (ledger.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write cycles_per_sample over the register port, then read it back.
  task automatic program_rate(input logic [15:0] v);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= RATE_ADDR;
    cfg_pwdata  <= {16'd0, v};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    ledger.set_rate(v);
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (cfg_prdata[15:0] !== v)
      ledger.report($sformatf("rate reads back %0d, written %0d", cfg_prdata[15:0], v));
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // Directed opening at the reset rate. All three tones start together at period
  // zero and full volume, with noise clocked by tone 2, so the second tick lands
  // every level low (exactly the negative limit) and the third every level high
  // (positive saturation). Then the ignored-byte cases, silencing, routing
  // extremes, white noise and the unused code.
  task automatic run_directed();
    issue(psgtn_pkg::FUNC_TICK, 8'hFF);     // nothing audible yet
    issue(psgtn_pkg::FUNC_DATA, 8'h80);     // tone 0 period, low bits zero
    issue(psgtn_pkg::FUNC_DATA, 8'hA0);
    issue(psgtn_pkg::FUNC_DATA, 8'hC0);
    issue(psgtn_pkg::FUNC_DATA, 8'hE3);     // periodic noise at the tone 2 rate
    issue(psgtn_pkg::FUNC_DATA, 8'hF0);     // noise at full volume
    issue(psgtn_pkg::FUNC_TICK, 8'h00);
    issue(psgtn_pkg::FUNC_TICK, 8'h00);
    issue(psgtn_pkg::FUNC_TICK, 8'h00);
    issue(psgtn_pkg::FUNC_DATA, 8'h3F);     // data byte while noise volume is latched: dropped
    issue(psgtn_pkg::FUNC_DATA, 8'hC5);
    issue(psgtn_pkg::FUNC_DATA, 8'h7F);     // tone 2 period upper bits to their maximum
    issue(psgtn_pkg::FUNC_DATA, 8'hDF);     // tone 2 silenced
    issue(psgtn_pkg::FUNC_DATA, 8'h2A);     // data byte after a volume latch: dropped
    issue(psgtn_pkg::FUNC_STEREO, 8'h5A);
    issue(psgtn_pkg::FUNC_TICK, 8'hFF);
    issue(psgtn_pkg::FUNC_STEREO, 8'h00);
    issue(psgtn_pkg::FUNC_TICK, 8'h55);
    issue(psgtn_pkg::FUNC_NONE, 8'hFF);     // unused code, no sample
    issue(psgtn_pkg::FUNC_DATA, 8'hEC);     // white noise, fastest rate, spare bit set
    issue(psgtn_pkg::FUNC_STEREO, psgtn_pkg::ROUTING_RESET);
    issue(psgtn_pkg::FUNC_TICK, 8'h00);
    issue(psgtn_pkg::FUNC_DATA, 8'h9E);     // tone 0 at its quietest audible step
    issue(psgtn_pkg::FUNC_TICK, 8'h00);
    issue(psgtn_pkg::FUNC_DATA, 8'hFF);     // noise off
    issue(psgtn_pkg::FUNC_TICK, 8'h00);
  endtask

  // Result side. Each edge first checks the beat that edge accepted, then decides
  // the next ready value: a requested freeze, a random stall, or ready.
  initial begin : sample_sink
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (out_valid === 1'b1 && out_ready)
        ledger.match_sample(out_left_sample, out_right_sample);
      if (sink_freeze_req) begin
        sink_freeze_req = 1'b0;
        hold = FREEZE_CYCLES;
      end
      if (hold == 0) hold = draw_gap(sink_eager);
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Stimulus: reset, the directed opening, then random phases at several rates.
  // Each phase starts from a drained block, which is also where the rate changes.
  // Phase 1 runs the sender flat out against a long receiver freeze; phase 3 runs
  // the receiver without stalls.
  initial begin : stimulus
    logic [15:0]      rates [NUM_PHASES];
    psgtn_pkg::func_t f;
    logic [7:0]       b;
    rates = '{16'd16, 16'hFFFF, 16'($urandom_range(16, 65535)), psgtn_pkg::CPS_RESET,
              16'($urandom_range(16, 300)), 16'($urandom_range(16, 65535))};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    run_directed();
    for (int p = 0; p < NUM_PHASES; p++) begin
      await_quiet();
      program_rate(rates[p]);
      source_eager = (p == 1);
      sink_eager   = (p == 3);
      if (p == 1) sink_freeze_req = 1'b1;
      repeat (PHASE_BEATS) begin
        pick_command(f, b);
        issue(f, b);
      end
    end
    await_quiet();
    if (ledger.fail_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  // Hang guard: a lost sample or a stuck handshake ends the run here.
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d samples outstanding", cycles,
             ledger.pending.size());
    $display("simulation failed");
    $finish;
  end

endmodule
